// ===== design/euclidean_distance_engine_core_defines.svh =====
// Assertion macros used by the checker of the distance engine.
`ifndef EUCLIDEAN_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication.
`define EDC_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define EDC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/edc_pkg.sv =====
package edc_pkg;

  localparam int unsigned Lanes       = 4;
  localparam int unsigned ElementBits = 16;
  localparam int unsigned FieldW      = 64;
  localparam int unsigned CountW      = 3;
  localparam int unsigned AccW        = 48;
  localparam int unsigned RootW       = AccW / 2;
  localparam int unsigned DiffW       = ElementBits + 1;
  localparam int unsigned SqW         = 2 * ElementBits + 1;
  localparam int unsigned SumW        = SqW + $clog2(Lanes);
  localparam int unsigned PadW        = (Lanes * ElementBits > FieldW) ?
                                        Lanes * ElementBits : FieldW;

  typedef struct packed {
    logic [FieldW-1:0] first_lanes;
    logic [FieldW-1:0] second_lanes;
    logic [CountW-1:0] lane_count;
    logic              last_chunk;
  } in_t;

  typedef struct packed {
    logic [RootW-1:0] distance;
    logic [AccW-1:0]  squared_sum;
    logic             saturated;
  } out_t;

  typedef logic [SqW-1:0] square_t;

  typedef struct packed {
    logic            load;
    logic [AccW-1:0] total;
    logic            sat;
  } root_load_t;

endpackage

// ===== design/edc_lane.sv =====
module edc_lane import edc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic [ElementBits-1:0] a_i,
  input  logic [ElementBits-1:0] b_i,
  input  logic                   active_i,
  output square_t                square_o
);

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag;
  logic [2*DiffW-1:0]      prod;
  square_t                 square_d, square_q;

  assign diff = $signed({a_i[ElementBits-1], a_i}) - $signed({b_i[ElementBits-1], b_i});
  assign mag  = diff[DiffW-1] ? unsigned'(DiffW'(-diff)) : unsigned'(diff);
  assign prod = mag * mag;

  assign square_d = active_i ? prod[SqW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      square_q <= square_d;
    end
  end

  assign square_o = square_q;

endmodule

// ===== design/edc_accum.sv =====
module edc_accum import edc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 last_i,
  input  square_t [Lanes-1:0]  squares_i,
  output root_load_t           load_o
);

  logic [SumW-1:0] sum;
  logic [AccW:0]   total;
  logic [AccW-1:0] clamped;
  logic            sat_now;
  logic [AccW-1:0] acc_d, acc_q;
  logic            sat_d, sat_q;

  always_comb begin
    sum = '0;
    for (int unsigned i = 0; i < Lanes; i++) begin
      sum = sum + SumW'(squares_i[i]);
    end
  end

  assign total   = (AccW+1)'(acc_q) + (AccW+1)'(sum);
  assign clamped = total[AccW] ? '1 : total[AccW-1:0];
  assign sat_now = sat_q | total[AccW];

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    if (valid_i) begin
      if (last_i) begin
        acc_d = '0;
        sat_d = 1'b0;
      end else begin
        acc_d = clamped;
        sat_d = sat_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign load_o.load  = valid_i & last_i;
  assign load_o.total = clamped;
  assign load_o.sat   = sat_now;

endmodule

// ===== design/edc_root.sv =====
module edc_root import edc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  root_load_t load_i,
  output logic       idle_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_o
);

  localparam int unsigned RemW = RootW + 3;
  localparam int unsigned CntW = $clog2(RootW);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } root_state_e;

  root_state_e     state_d, state_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [AccW-1:0] x_d, x_q;
  logic [RemW-1:0] rem_d, rem_q;
  logic [RootW-1:0] root_d, root_q;
  logic [AccW-1:0] sum_d, sum_q;
  logic            sat_d, sat_q;
  logic            out_valid_d, out_valid_q;
  out_t            out_d, out_q;
  logic [RemW-1:0] rem_sh, trial;

  assign rem_sh = {rem_q[RemW-3:0], x_q[AccW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      StIdle: begin
        if (load_i.load) begin
          x_d     = load_i.total;
          sum_d   = load_i.total;
          sat_d   = load_i.sat;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        x_d = {x_q[AccW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(RootW - 1)) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.distance    = root_q;
          out_d.squared_sum = sum_q;
          out_d.saturated   = sat_q;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sum_q  <= sum_d;
    sat_q  <= sat_d;
    out_q  <= out_d;
  end

  assign idle_o      = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== design/euclidean_distance_engine_core.sv =====
// Euclidean distance engine: takes two vectors as a stream of chunks of four signed Q8.8
// element pairs, squares the lane differences in four parallel lanes, merges them into a
// saturating 48-bit sum of squares and, on the chunk marked last, returns floor(sqrt) of
// the total as Q16.8 together with the total and its saturation flag. Ordinary chunks are
// taken one per cycle. A last chunk closes the pair: the block then takes no item until the
// square-root unit, which resolves one result bit per cycle, has moved its result into the
// output register, where a finished result waits while new chunks stream in.
module euclidean_distance_engine_core import edc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic                accept;
  logic [PadW-1:0]     first_pad, second_pad;
  square_t [Lanes-1:0] squares;
  logic                s1_valid_q, s1_last_q;
  root_load_t          root_load;
  logic                root_idle;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = root_idle & ~(s1_valid_q & s1_last_q);
  assign first_pad  = PadW'(in_i.first_lanes);
  assign second_pad = PadW'(in_i.second_lanes);

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    edc_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (accept),
      .a_i      (first_pad[g*ElementBits +: ElementBits]),
      .b_i      (second_pad[g*ElementBits +: ElementBits]),
      .active_i (in_i.lane_count > CountW'(g)),
      .square_o (squares[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_last_q  <= accept & in_i.last_chunk;
    end
  end

  edc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .last_i    (s1_last_q),
    .squares_i (squares),
    .load_o    (root_load)
  );

  edc_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (root_load),
    .idle_o      (root_idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== design/edc_checker.sv =====
`include "euclidean_distance_engine_core_defines.svh"

module edc_props import edc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  logic [2*RootW-1:0] dist_sq;
  logic [RootW:0]     dist_inc;
  logic [2*RootW+1:0] next_sq;

  assign dist_sq  = (2*RootW)'(out_o.distance) * (2*RootW)'(out_o.distance);
  assign dist_inc = (RootW+1)'(out_o.distance) + 1'b1;
  assign next_sq  = (2*RootW+2)'(dist_inc) * (2*RootW+2)'(dist_inc);

  `EDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result item dropped before it was taken")
  `EDC_ASSERT_SAME(a_root_floor, clk_i, rst_ni, out_valid_o, (dist_sq <= out_o.squared_sum) && (next_sq > (2*RootW+2)'(out_o.squared_sum)), "distance is not the floor root of the sum")
  `EDC_ASSERT_SAME(a_sat_value, clk_i, rst_ni, out_valid_o && out_o.saturated, out_o.squared_sum == '1, "saturated flag without a clamped sum")
  `EDC_ASSERT_NEXT(a_last_blocks, clk_i, rst_ni, in_valid_i && in_ready_o && in_i.last_chunk, !in_ready_o, "item taken right after a last chunk")

endmodule

bind euclidean_distance_engine_core edc_props u_checker (.*);
